[rtl/cosine_pade_rational_top_macros.svh]
// Assertion macros for the cosine Pade block; clk_i and rst_ni are in scope.
`ifndef COSINE_PADE_RATIONAL_TOP_MACROS_SVH
`define COSINE_PADE_RATIONAL_TOP_MACROS_SVH

// same-cycle implication
`define CPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cpr_pkg.sv]
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared constants and types of the cosine Pade rational block.
// ----------------------------------------------------------------------------
`default_nettype none

package cpr_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;

  // powers of x are unsigned Q.32
  localparam int unsigned PW_FRAC = 32;
  localparam int unsigned X2W     = 37;
  localparam int unsigned X4W     = 41;
  localparam int unsigned X6W     = 45;
  localparam int unsigned SW      = 64;   // polynomial sums
  localparam int unsigned RW      = 66;   // divider remainder
  localparam int unsigned IB      = 3;    // integer quotient bits

  localparam logic [SW-1:0] C0  = 64'd39251520 << PW_FRAC;
  localparam logic [24:0]   NC1 = 25'd18471600;
  localparam logic [20:0]   NC2 = 21'd1075032;
  localparam logic [13:0]   NC3 = 14'd14615;
  localparam logic [20:0]   DC1 = 21'd1154160;
  localparam logic [14:0]   DC2 = 15'd16632;
  localparam logic [6:0]    DC3 = 7'd127;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

[rtl/cosine_pade_rational_top.sv]
// From accepted angle to cosine a word passes the front register, the queue and the back
// pipeline (powers, sums, divider).
// Throughput: one word per cycle while out_stall_i is low; the divider is fully pipelined, one stage a bit.
// Reset clears all valid flags and queue pointers; data registers are not reset.
// ----------------------------------------------------------------------------
// cosine_pade_rational_top
// Cosine of a Q2.x angle by the even [6/6] Pade approximant, saturated Q2.x.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cosine_pade_rational_top_macros.svh"

module cosine_pade_rational_top #(
  parameter int unsigned DATA_WIDTH = cpr_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [DATA_WIDTH-1:0] angle_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [DATA_WIDTH-1:0]      cosine_o
);

  logic                  push, pop, back_rdy, front_v;
  logic [DATA_WIDTH-1:0] f_mag, q_mag;
  cpr_pkg::q_stat_t      q_stat;

  assign pop     = !q_stat.empty && back_rdy;
  assign front_v = push || in_stall_o;

  cpr_front #(.DW(DATA_WIDTH)) u_front (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .angle_i(angle_i),
    .push_ok_i(!q_stat.full), .push_o(push), .mag_o(f_mag)
  );

  cpr_fifo #(.W(DATA_WIDTH)) u_fifo (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push_i(push), .data_i(f_mag), .pop_i(pop), .data_o(q_mag), .stat_o(q_stat)
  );

  cpr_back #(.DW(DATA_WIDTH)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .take_i(pop), .mag_i(q_mag), .ready_o(back_rdy),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .cosine_o(cosine_o)
  );

  `CPR_ASSERT_NOW(a_q_consistent, q_stat.full, !q_stat.empty, "queue full and empty")
  `CPR_ASSERT_NOW(a_q_fill, $rose(q_stat.full), $past(push), "queue filled without push")
  `CPR_ASSERT_NEXT(a_front_hold, front_v && q_stat.full && !pop, front_v, "front word lost")

endmodule

`default_nettype wire

[rtl/cpr_front.sv]
// ----------------------------------------------------------------------------
// cpr_front
// Input register: takes the angle word and forms its magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_front #(
  parameter int unsigned DW = cpr_pkg::DATA_WIDTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [DW-1:0] angle_i,
  input  wire logic          push_ok_i,
  output logic               push_o,
  output logic [DW-1:0]      mag_o
);

  logic          v_q, v_d;
  logic [DW-1:0] mag_q;
  logic          take;

  assign push_o     = v_q && push_ok_i;
  assign in_stall_o = v_q && !push_ok_i;
  assign take       = in_valid_i && !in_stall_o;
  assign mag_o      = mag_q;

  always_comb begin
    v_d = v_q;
    if (push_o) v_d = 1'b0;
    if (take)   v_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else         v_q <= v_d;
  end

  // most negative code becomes 2^(DW-1) as unsigned
  always_ff @(posedge clk_i) begin
    if (take) mag_q <= angle_i[DW-1] ? (~angle_i + 1'b1) : angle_i;
  end

endmodule

`default_nettype wire

[rtl/cpr_fifo.sv]
// ----------------------------------------------------------------------------
// cpr_fifo
// Two-entry queue between the front register and the arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_fifo #(
  parameter int unsigned W = cpr_pkg::DATA_WIDTH_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  input  wire logic         pop_i,
  output logic [W-1:0]      data_o,
  output cpr_pkg::q_stat_t  stat_o
);

  logic [W-1:0] mem [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q, cnt_d;

  assign stat_o.full  = cnt_q[1];
  assign stat_o.empty = (cnt_q == 2'd0);
  assign data_o       = mem[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 2'd1;
    if (pop_i && !push_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem[wp_q] <= data_i;
  end

endmodule

`default_nettype wire

[rtl/cpr_mul.sv]
// ----------------------------------------------------------------------------
// cpr_mul
// Two-stage unsigned multiplier: partial products on the halves of b, then sum.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [AW-1:0]   a_i,
  input  wire logic [BW-1:0]   b_i,
  output logic [AW+BW-1:0]     p_o
);

  localparam int unsigned BL = (BW + 1) / 2;
  localparam int unsigned BH = BW - BL;

  logic [AW+BL-1:0] lo_q;
  logic [AW+BH-1:0] hi_q;
  logic [AW+BW-1:0] p_q;

  assign p_o = p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q <= a_i * b_i[BL-1:0];
      hi_q <= a_i * b_i[BW-1:BL];
      p_q  <= {hi_q, {BL{1'b0}}} + (AW+BW)'(lo_q);
    end
  end

endmodule

`default_nettype wire

[rtl/cpr_back.sv]
// ----------------------------------------------------------------------------
// cpr_back
// Arithmetic pipeline: powers of x, both cubics, bit-per-stage divider,
// rounding and saturation into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_back #(
  parameter int unsigned DW = cpr_pkg::DATA_WIDTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          take_i,
  input  wire logic [DW-1:0] mag_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [DW-1:0]      cosine_o
);

  localparam int unsigned X2W = cpr_pkg::X2W;
  localparam int unsigned X4W = cpr_pkg::X4W;
  localparam int unsigned X6W = cpr_pkg::X6W;
  localparam int unsigned SW  = cpr_pkg::SW;
  localparam int unsigned RW  = cpr_pkg::RW;
  localparam int unsigned QW  = DW + 1;
  localparam int unsigned LAT = 15 + QW;
  localparam int          SH  = 2 * (int'(DW) - 3) - int'(cpr_pkg::PW_FRAC);

  logic           en;
  logic [LAT-1:0] v_q;

  assign en          = !(v_q[LAT-1] && out_stall_i);
  assign ready_o     = en;
  assign out_valid_o = v_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)  v_q <= '0;
    else if (en)  v_q <= {v_q[LAT-2:0], take_i};
  end

  // x^2
  logic [DW-1:0]    m_q;
  logic [2*DW-1:0]  p2;
  logic [X2W-1:0]   x2_q;
  logic [X2W-1:0]   x2_n;

  always_ff @(posedge clk_i) begin
    if (en) m_q <= mag_i;
  end

  cpr_mul #(.AW(DW), .BW(DW)) u_mul_x2 (
    .clk_i(clk_i), .en_i(en), .a_i(m_q), .b_i(m_q), .p_o(p2)
  );

  generate
    if (SH > 0) begin : g_rnd
      logic [2*DW:0] t;
      assign t    = {1'b0, p2} + ((2*DW+1)'(1) << (SH - 1));
      assign x2_n = t[SH +: X2W];
    end else begin : g_shl
      assign x2_n = X2W'(p2) << (-SH);
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    if (en) x2_q <= x2_n;
  end

  // x^4, x^6 with aligned delay lines
  logic [X2W-1:0]     x2_dl [6];
  logic [X4W-1:0]     x4_dl [3];
  logic [2*X2W-1:0]   p4;
  logic [X4W+X2W-1:0] p6;
  logic [X4W-1:0]     x4_q;
  logic [X6W-1:0]     x6_q;
  logic [2*X2W:0]     p4r;
  logic [X4W+X2W:0]   p6r;

  cpr_mul #(.AW(X2W), .BW(X2W)) u_mul_x4 (
    .clk_i(clk_i), .en_i(en), .a_i(x2_q), .b_i(x2_q), .p_o(p4)
  );

  cpr_mul #(.AW(X4W), .BW(X2W)) u_mul_x6 (
    .clk_i(clk_i), .en_i(en), .a_i(x4_q), .b_i(x2_dl[2]), .p_o(p6)
  );

  assign p4r = {1'b0, p4} + (2*X2W+1)'(33'h080000000);
  assign p6r = {1'b0, p6} + (X4W+X2W+1)'(33'h080000000);

  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_dl[0] <= x2_q;
      for (int i = 1; i < 6; i++) x2_dl[i] <= x2_dl[i-1];
      x4_q     <= p4r[cpr_pkg::PW_FRAC +: X4W];
      x4_dl[0] <= x4_q;
      for (int i = 1; i < 3; i++) x4_dl[i] <= x4_dl[i-1];
      x6_q     <= p6r[cpr_pkg::PW_FRAC +: X6W];
    end
  end

  // coefficient products, then the two sums in two steps
  logic [SW-1:0]        t1_q, t2_q, t3_q, u1_q, u2_q, u3_q;
  logic signed [SW-1:0] na_q, nb_q, da_q, db_q, num_q, den_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q  <= SW'(cpr_pkg::NC1) * SW'(x2_dl[5]);
      t2_q  <= SW'(cpr_pkg::NC2) * SW'(x4_dl[2]);
      t3_q  <= SW'(cpr_pkg::NC3) * SW'(x6_q);
      u1_q  <= SW'(cpr_pkg::DC1) * SW'(x2_dl[5]);
      u2_q  <= SW'(cpr_pkg::DC2) * SW'(x4_dl[2]);
      u3_q  <= SW'(cpr_pkg::DC3) * SW'(x6_q);
      na_q  <= $signed(cpr_pkg::C0 - t1_q);
      nb_q  <= $signed(t2_q - t3_q);
      da_q  <= $signed(cpr_pkg::C0 + u1_q);
      db_q  <= $signed(u2_q + u3_q);
      num_q <= na_q + nb_q;
      den_q <= da_q + db_q;
    end
  end

  // divider: one quotient bit per stage, first bit weighs 2^(IB-1)
  logic [RW-1:0] r_q  [QW+1];
  logic [RW-1:0] dd_q [QW+1];
  logic [QW-1:0] q_q  [QW+1];
  logic          ng_q [QW+1];
  logic [SW-1:0] nmag;

  assign nmag = num_q[SW-1] ? (~num_q + 1'b1) : num_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q[0]  <= RW'(nmag);
      dd_q[0] <= RW'(den_q) << (cpr_pkg::IB - 1);
      q_q[0]  <= '0;
      ng_q[0] <= num_q[SW-1];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic          ge;
    logic [RW-1:0] r1;
    assign ge = (r_q[j] >= dd_q[j]);
    assign r1 = ge ? (r_q[j] - dd_q[j]) : r_q[j];
    always_ff @(posedge clk_i) begin
      if (en) begin
        r_q[j+1]  <= {r1[RW-2:0], 1'b0};
        dd_q[j+1] <= dd_q[j];
        q_q[j+1]  <= {q_q[j][QW-2:0], ge};
        ng_q[j+1] <= ng_q[j];
      end
    end
  end

  // round half away from zero, then saturate
  logic [QW:0]   qinc;
  logic [QW-1:0] qr, half, sat;
  logic [DW-1:0] res;
  logic [DW-1:0] cos_q;

  assign qinc = {1'b0, q_q[QW]} + 1'b1;
  assign qr   = qinc[QW:1];
  assign half = QW'(1) << (DW - 1);

  always_comb begin
    if (ng_q[QW]) begin
      sat = (qr > half) ? half : qr;
      res = DW'(~sat + 1'b1);
    end else begin
      sat = (qr > half - 1'b1) ? (half - 1'b1) : qr;
      res = sat[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) cos_q <= res;
  end

  assign cosine_o = cos_q;

endmodule

`default_nettype wire
